>>> design/sph_pkg.sv
// Shared types and constants for the spherical-to-Cartesian converter.
package sph_pkg;

   // Input transfer: two binary angles, 32768 stands for pi
   typedef struct packed {
      logic signed [15:0] inclination;
      logic signed [15:0] azimuth;
   } req_type;

   // Result transfer: point and both Jacobian columns, Q1.15
   typedef struct packed {
      logic signed [15:0] point_x;
      logic signed [15:0] point_y;
      logic signed [15:0] point_z;
      logic signed [15:0] d_inc_x;
      logic signed [15:0] d_inc_y;
      logic signed [15:0] d_inc_z;
      logic signed [15:0] d_az_x;
      logic signed [15:0] d_az_y;
      logic signed [15:0] d_az_z;
   } rsp_type;

   // Register indexes
   typedef enum logic [1:0] {
      CSR_AXIS_ONE   = 2'd0,
      CSR_AXIS_TWO   = 2'd1,
      CSR_AXIS_THREE = 2'd2
   } csr_index_type;

   localparam int AxisW = 48;
   localparam logic [AxisW-1:0] AXIS_ONE_RST   = 48'd16384;
   localparam logic [AxisW-1:0] AXIS_TWO_RST   = 48'd1073741824;
   localparam logic [AxisW-1:0] AXIS_THREE_RST = 48'd70368744177664;

   // CORDIC in Q4.30 with angle in binary units
   localparam int CordicW   = 34;
   localparam int AngleW    = 18;
   localparam int CordicN   = 16;
   localparam int IterPerSt = 4;
   localparam int CordicSt  = CordicN / IterPerSt;
   localparam logic signed [CordicW-1:0] CORDIC_START = 34'sd652032876;
   localparam logic signed [AngleW-1:0] ATAN_UNITS [CordicN] = '{
      18'sd8192, 18'sd4836, 18'sd2555, 18'sd1297, 18'sd651, 18'sd326, 18'sd163,
      18'sd81, 18'sd41, 18'sd20, 18'sd10, 18'sd5, 18'sd3, 18'sd1, 18'sd1, 18'sd0
   };

endpackage

>>> design/spherical_to_cartesian_param.sv
// Top level: pipelined spherical-to-Cartesian map in a programmable frame.
//
//  channel | ports                           | direction | moves
//  --------+---------------------------------+-----------+------------------------
//  request | req_valid req_stall req_data    | in        | inclination, azimuth
//  result  | rsp_valid rsp_stall rsp_data    | out       | point, d_inc, d_az
//  config  | csr_we csr_index csr_wdata      | in        | frame axes one..three
//
//  Nine register stages: fold, four CORDIC stages of four iterations, round,
//  coefficient multiply, axis multiply, sum and saturate (the result register).
//  One transfer per cycle while the result side does not stall.
//  Synchronous reset empties the pipe and restores the unit frame axes.
//  A stalled result holds its stage; upstream stages fill bubbles and stall
//  only once every stage ahead of them is full.
module spherical_to_cartesian_param (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sph_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sph_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [47:0]      csr_wdata
);
   import sph_pkg::*;

   localparam int NSt = 9;

   // Pipeline control
   logic [NSt:1]   v_ff;
   logic [NSt+1:1] ready;

   // Frame axes
   logic [AxisW-1:0] axis_ff [3];

   // Stage 1: folded angles
   logic signed [AngleW-1:0] fz_ff [2];
   logic                     fneg_ff [2];

   // Stages 2..5: CORDIC
   logic signed [CordicW-1:0] cx_ff [CordicSt][2];
   logic signed [CordicW-1:0] cy_ff [CordicSt][2];
   logic signed [AngleW-1:0]  cz_ff [CordicSt][2];
   logic                      cneg_ff [CordicSt][2];

   // Stage 6: sine and cosine, lane 0 inclination, lane 1 azimuth
   logic signed [16:0] sn_ff [2];
   logic signed [16:0] cs_ff [2];

   // Stage 7: Q30 coefficients
   logic signed [31:0] k_ff [9];

   // Stage 8: coefficient times axis component [output group][component][axis]
   logic signed [47:0] p_ff [3][3][3];

   // Stage 9: result
   rsp_type rsp_ff;

   // Build ready chain from the output back
   always_comb begin
      ready[NSt+1] = !rsp_stall;
      for (int k = NSt; k >= 1; k--) begin
         ready[k] = !v_ff[k] || ready[k+1];
      end
   end

   assign req_stall = !ready[1];
   assign rsp_valid = v_ff[NSt];
   assign rsp_data  = rsp_ff;

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (ready[1]) begin
            v_ff[1] <= req_valid;
         end
         for (int k = 2; k <= NSt; k++) begin
            if (ready[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // Configuration writes; unknown index is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff[0] <= AXIS_ONE_RST;
         axis_ff[1] <= AXIS_TWO_RST;
         axis_ff[2] <= AXIS_THREE_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_AXIS_ONE:   axis_ff[0] <= csr_wdata;
            CSR_AXIS_TWO:   axis_ff[1] <= csr_wdata;
            CSR_AXIS_THREE: axis_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Stage 1: fold angle into [-pi/2, pi/2]
   logic signed [AngleW-1:0] fz_in [2];
   logic                     fneg_in [2];
   always_comb begin
      logic signed [AngleW-1:0] a;
      for (int l = 0; l < 2; l++) begin
         a = (l == 0) ? AngleW'(req_data.inclination) : AngleW'(req_data.azimuth);
         fz_in[l]   = a;
         fneg_in[l] = 1'b0;
         if (a > 18'sd16384) begin
            fz_in[l]   = a - 18'sd32768;
            fneg_in[l] = 1'b1;
         end else if (a < -18'sd16384) begin
            fz_in[l]   = a + 18'sd32768;
            fneg_in[l] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready[1]) begin
         fz_ff   <= fz_in;
         fneg_ff <= fneg_in;
      end
   end

   // Stages 2..5: four CORDIC iterations per stage
   for (genvar g = 0; g < CordicSt; g++) begin : g_cordic
      localparam int Prev = (g == 0) ? 0 : g - 1;
      logic signed [CordicW-1:0] x_in [2];
      logic signed [CordicW-1:0] y_in [2];
      logic signed [AngleW-1:0]  z_in [2];
      always_comb begin
         logic signed [CordicW-1:0] x, y, dx, dy;
         logic signed [AngleW-1:0]  z;
         for (int l = 0; l < 2; l++) begin
            if (g == 0) begin
               x = CORDIC_START;
               y = '0;
               z = fz_ff[l];
            end else begin
               x = cx_ff[Prev][l];
               y = cy_ff[Prev][l];
               z = cz_ff[Prev][l];
            end
            for (int j = 0; j < IterPerSt; j++) begin
               dx = y >>> (g*IterPerSt + j);
               dy = x >>> (g*IterPerSt + j);
               if (z >= 0) begin
                  x = x - dx;
                  y = y + dy;
                  z = z - ATAN_UNITS[g*IterPerSt + j];
               end else begin
                  x = x + dx;
                  y = y - dy;
                  z = z + ATAN_UNITS[g*IterPerSt + j];
               end
            end
            x_in[l] = x;
            y_in[l] = y;
            z_in[l] = z;
         end
      end

      always_ff @(posedge clock) begin
         if (ready[g+2]) begin
            cx_ff[g] <= x_in;
            cy_ff[g] <= y_in;
            cz_ff[g] <= z_in;
            for (int l = 0; l < 2; l++) begin
               cneg_ff[g][l] <= (g == 0) ? fneg_ff[l] : cneg_ff[Prev][l];
            end
         end
      end
   end

   // Stage 6: round half up to Q15, clamp, undo fold
   function automatic logic signed [16:0] round_q15(input logic signed [CordicW-1:0] v,
                                                    input logic neg);
      logic signed [CordicW-1:0] t;
      logic signed [16:0]        r;
      t = (v + 34'sd16384) >>> 15;
      if (t > 34'sd32768)       r = 17'sd32768;
      else if (t < -34'sd32768) r = -17'sd32768;
      else                      r = t[16:0];
      return neg ? -r : r;
   endfunction

   always_ff @(posedge clock) begin
      if (ready[6]) begin
         for (int l = 0; l < 2; l++) begin
            cs_ff[l] <= round_q15(cx_ff[CordicSt-1][l], cneg_ff[CordicSt-1][l]);
            sn_ff[l] <= round_q15(cy_ff[CordicSt-1][l], cneg_ff[CordicSt-1][l]);
         end
      end
   end

   // Stage 7: coefficients in Q30
   logic signed [31:0] k_in [9];
   always_comb begin
      logic signed [16:0] si, ci, sa, ca;
      si = sn_ff[0];
      ci = cs_ff[0];
      sa = sn_ff[1];
      ca = cs_ff[1];
      k_in[0] = 32'(ca * si);
      k_in[1] = 32'(sa * si);
      k_in[2] = 32'(ci) <<< 15;
      k_in[3] = 32'(ca * ci);
      k_in[4] = 32'(sa * ci);
      k_in[5] = -(32'(si) <<< 15);
      k_in[6] = -32'(sa * si);
      k_in[7] = 32'(ca * si);
      k_in[8] = '0;
   end

   always_ff @(posedge clock) begin
      if (ready[7]) begin
         k_ff <= k_in;
      end
   end

   // Stage 8: multiply each coefficient by its Q14 axis component
   always_ff @(posedge clock) begin
      if (ready[8]) begin
         for (int o = 0; o < 3; o++) begin
            for (int c = 0; c < 3; c++) begin
               for (int m = 0; m < 3; m++) begin
                  p_ff[o][c][m] <= 48'(k_ff[3*o+m] * signed'(axis_ff[m][16*c +: 16]));
               end
            end
         end
      end
   end

   // Stage 9: sum, round half up to Q15, saturate
   logic signed [15:0] res [3][3];
   always_comb begin
      logic signed [49:0] acc;
      for (int o = 0; o < 3; o++) begin
         for (int c = 0; c < 3; c++) begin
            acc = 50'(p_ff[o][c][0]) + 50'(p_ff[o][c][1]) + 50'(p_ff[o][c][2])
                  + 50'sd268435456;
            acc = acc >>> 29;
            if (acc > 50'sd32767)       res[o][c] = 16'sh7fff;
            else if (acc < -50'sd32768) res[o][c] = 16'sh8000;
            else                        res[o][c] = acc[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready[9]) begin
         rsp_ff.point_x <= res[0][0];
         rsp_ff.point_y <= res[0][1];
         rsp_ff.point_z <= res[0][2];
         rsp_ff.d_inc_x <= res[1][0];
         rsp_ff.d_inc_y <= res[1][1];
         rsp_ff.d_inc_z <= res[1][2];
         rsp_ff.d_az_x  <= res[2][0];
         rsp_ff.d_az_y  <= res[2][1];
         rsp_ff.d_az_z  <= res[2][2];
      end
   end

   // Pipe is empty right after reset
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> v_ff == '0)
      else $error("pipeline not empty after reset");

   // A free output never back-pressures the request side
   a_no_stall_when_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("request stalled while result side is free");

   // Request stall only with every stage full
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (v_ff == '1))
      else $error("request stalled with a bubble in the pipe");

   // A stalled full first stage keeps its item
   a_hold_item: assert property (@(posedge clock) disable iff (reset)
      (v_ff[1] && !ready[2]) |=> v_ff[1])
      else $error("stalled item dropped from first stage");

endmodule

>>> tb/sv/tb.sv
// Testbench for the spherical-to-Cartesian converter: predicts and checks every result.
`timescale 1ns / 100ps

module tb;
   import sph_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [47:0] csr_wdata = '0;

   // Frame axes as the block should currently hold them
   logic [47:0] axis_one = AXIS_ONE_RST;
   logic [47:0] axis_two = AXIS_TWO_RST;
   logic [47:0] axis_three = AXIS_THREE_RST;

   rsp_type     expected_points [$];
   int          errors = 0;
   int          cycles = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          hold_cycles = 0;
   logic        hold_request = 1'b0;

   localparam int Latency = 9;
   localparam int CycleLimit = 400000;
   localparam int HoldLength = 200;
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   spherical_to_cartesian_param dut (.*);

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Bound the run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("status: fail");
         $finish;
      end
   end

   // Sine and cosine of a binary angle, rounded to Q15
   function automatic void sin_cos(input longint ang, output longint s, output longint c);
      longint x, y, z, dx, dy;
      bit     neg;
      neg = 1'b0;
      if (ang > 16384) begin
         ang -= 32768;
         neg = 1'b1;
      end else if (ang < -16384) begin
         ang += 32768;
         neg = 1'b1;
      end
      x = longint'(CORDIC_START);
      y = 0;
      z = ang;
      for (int i = 0; i < CordicN; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(ATAN_UNITS[i]);
         end else begin
            x += dx; y -= dy; z += longint'(ATAN_UNITS[i]);
         end
      end
      x = (x + (64'sd1 <<< 14)) >>> 15;
      y = (y + (64'sd1 <<< 14)) >>> 15;
      if (x > 32768) x = 32768;
      if (x < -32768) x = -32768;
      if (y > 32768) y = 32768;
      if (y < -32768) y = -32768;
      c = neg ? -x : x;
      s = neg ? -y : y;
   endfunction

   // Weighted sum of one axis component, Q30 times Q14 down to saturated Q15
   function automatic logic signed [15:0] frame_sum(input longint k1, k2, k3, input int comp);
      longint acc;
      acc = k1 * longint'($signed(axis_one[16*comp +: 16]))
          + k2 * longint'($signed(axis_two[16*comp +: 16]))
          + k3 * longint'($signed(axis_three[16*comp +: 16]));
      acc = (acc + (64'sd1 <<< 28)) >>> 29;
      if (acc > 32767) acc = 32767;
      if (acc < -32768) acc = -32768;
      return acc[15:0];
   endfunction

   function automatic rsp_type sphere_point(input req_type angles);
      longint  si, ci, sa, ca;
      rsp_type r;
      sin_cos(longint'(angles.inclination), si, ci);
      sin_cos(longint'(angles.azimuth), sa, ca);
      r.point_x = frame_sum(ca * si, sa * si, ci * 32768, 0);
      r.point_y = frame_sum(ca * si, sa * si, ci * 32768, 1);
      r.point_z = frame_sum(ca * si, sa * si, ci * 32768, 2);
      r.d_inc_x = frame_sum(ca * ci, sa * ci, -si * 32768, 0);
      r.d_inc_y = frame_sum(ca * ci, sa * ci, -si * 32768, 1);
      r.d_inc_z = frame_sum(ca * ci, sa * ci, -si * 32768, 2);
      r.d_az_x  = frame_sum(-sa * si, ca * si, 0, 0);
      r.d_az_y  = frame_sum(-sa * si, ca * si, 0, 1);
      r.d_az_z  = frame_sum(-sa * si, ca * si, 0, 2);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int field, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("mismatch %s field %0d got %0d want %0d at cycle %0d", what, field,
               $signed(got), $signed(want), cycles);
      errors++;
   endtask

   // Predict on each accepted request transfer
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         expected_points.push_back(sphere_point(req_data));
   end

   // Check each result transfer
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_points.size() == 0) begin
            report_mismatch("unexpected result", 0, '0, '0);
         end else begin
            want = expected_points.pop_front();
            for (int f = 0; f < 9; f++)
               if (rsp_data[143-16*f -: 16] !== want[143-16*f -: 16])
                  report_mismatch("result", f, rsp_data[143-16*f -: 16],
                                  want[143-16*f -: 16]);
         end
      end
   end

   // Drive result stall; count down a long hold-off when one is requested
   always @(posedge clock) begin
      if (hold_request && hold_cycles == 0) begin
         hold_cycles <= HoldLength - 1;
         rsp_stall <= 1'b1;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Offer one angle pair, hold it until the transfer
   task automatic send_angles(input logic [15:0] inc, input logic [15:0] az);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data.inclination <= inc;
      req_data.azimuth <= az;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Drop valid, wait for every expected result, then wait for the pipe to empty
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_points.size() != 0) @(posedge clock);
      repeat (Latency + 3) @(posedge clock);
   endtask

   task automatic write_axis(input logic [1:0] idx, input logic [47:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_AXIS_ONE:   axis_one = value;
         CSR_AXIS_TWO:   axis_two = value;
         CSR_AXIS_THREE: axis_three = value;
         default: ;
      endcase
   endtask

   task automatic set_frame(input logic [47:0] a1, a2, a3);
      write_axis(CSR_AXIS_ONE, a1);
      write_axis(CSR_AXIS_TWO, a2);
      write_axis(CSR_AXIS_THREE, a3);
   endtask

   // Angle extremes, fold boundaries and wrap, in the reset frame
   task automatic test_angle_extremes();
      logic [15:0] corners [8] = '{16'h0000, 16'h4000, 16'hC000, 16'h4001, 16'hBFFF,
                                   16'h7FFF, 16'h8000, 16'h0001};
      for (int i = 0; i < 8; i++)
         send_angles(corners[i], corners[(i * 3 + 1) % 8]);
      for (int i = 0; i < 8; i++)
         send_angles(corners[(i + 5) % 8], corners[i]);
      drain();
   endtask

   // Extreme and skewed axes that drive the sums into saturation
   task automatic test_frame_extremes();
      set_frame(48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF);
      for (int i = 0; i < 4; i++) send_angles(16'(i * 16'h2000), 16'(i * 16'h1000));
      drain();
      set_frame(48'h8000_8000_8000, 48'hFFFF_FFFF_FFFF, 48'h0000_0000_0000);
      for (int i = 0; i < 4; i++) send_angles(16'(i * 16'hE000), 16'(i * 16'h6000));
      drain();
      // Unused index must leave the frame alone
      write_axis(CSR_UNUSED, 48'h1234_5678_9ABC);
      send_angles(16'h3000, 16'hD000);
      drain();
   endtask

   // Random angle pairs under the current idling mix, fresh frame each phase
   task automatic test_random(input int count, input bit unit_frame);
      logic [15:0] inc, az;
      if (unit_frame)
         set_frame(AXIS_ONE_RST, AXIS_TWO_RST, AXIS_THREE_RST);
      else
         set_frame(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                   48'({$urandom, $urandom}));
      for (int n = 0; n < count; n++) begin
         inc = 16'($urandom);
         az = 16'($urandom);
         // Bias some angles onto the fold points
         if ($urandom_range(9) == 0) inc = 16'(32'h4000 + $urandom_range(2) - 1);
         if ($urandom_range(9) == 0) az = 16'(32'hC000 + $urandom_range(2) - 1);
         send_angles(inc, az);
      end
      drain();
   endtask

   // Long receiver hold-off while requests keep coming, so the pipe fills
   task automatic test_backpressure();
      hold_request <= 1'b1;
      @(posedge clock);
      hold_request <= 1'b0;
      for (int n = 0; n < 60; n++) send_angles(16'($urandom), 16'($urandom));
      drain();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_angle_extremes();
      test_frame_extremes();
      send_idle_pct = 27; recv_idle_pct = 77;
      test_random(250, 1'b1);
      test_random(250, 1'b0);
      send_idle_pct = 77; recv_idle_pct = 27;
      test_random(250, 1'b1);
      test_random(250, 1'b0);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_backpressure();
      test_random(250, 1'b0);
      test_random(250, 1'b1);
      if (errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

>>> filelist.f
design/sph_pkg.sv
design/spherical_to_cartesian_param.sv
tb/sv/tb.sv
